@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the compass heading RTL.
// Each macro checks one implication on the rising clock edge, with the
// checks switched off while the active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

@@ src/chmc_pkg.sv @@
// ---------------------------------------------------------------------------
// chmc_pkg
// Shared types, codes and constants of the compass heading block.
// ---------------------------------------------------------------------------
package chmc_pkg;

    // Command codes.
    localparam logic [1:0] CMD_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_START  = 2'd1;
    localparam logic [1:0] CMD_STOP   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_OVF     = 2'd1;
    localparam logic [1:0] ST_NONE    = 2'd2;

    localparam int SAMPLE_W     = 16;
    localparam int HEADING_W    = 9;
    localparam int DXY_W        = 18;          // offset-corrected axis value
    localparam int FRAC_SHIFT   = 16;          // fixed-point scale of the vector
    localparam int XY_W         = DXY_W + FRAC_SHIFT + 2;
    localparam int ANGLE_W      = 19;          // degrees with 8 fraction bits
    localparam int ATAN_ENTRIES = 24;
    localparam int ATAN_IDX_W   = 5;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam logic signed [SAMPLE_W-1:0] OVF_LIMIT     = -16'sd2048;
    localparam logic signed [SAMPLE_W-1:0] CAL_LOW_INIT  = 16'sd3000;
    localparam logic signed [SAMPLE_W-1:0] CAL_HIGH_INIT = -16'sd3000;
    localparam logic signed [ANGLE_W-1:0]  HALF_TURN_Q8  = 19'sd46080;
    localparam logic [HEADING_W-1:0]       HEADING_MAX   = 9'd359;

    typedef struct packed {
        logic busy;
        logic done;
    } cordic_stat_t;

    // atan(2^-i) in degrees, scaled by 256 and rounded.
    function automatic logic signed [ANGLE_W-1:0] atan_q8(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [ANGLE_W-1:0] v;
        case (idx)
            5'd0:    v = 19'sd11520;
            5'd1:    v = 19'sd6801;
            5'd2:    v = 19'sd3593;
            5'd3:    v = 19'sd1824;
            5'd4:    v = 19'sd916;
            5'd5:    v = 19'sd458;
            5'd6:    v = 19'sd229;
            5'd7:    v = 19'sd115;
            5'd8:    v = 19'sd57;
            5'd9:    v = 19'sd29;
            5'd10:   v = 19'sd14;
            5'd11:   v = 19'sd7;
            5'd12:   v = 19'sd4;
            5'd13:   v = 19'sd2;
            5'd14:   v = 19'sd1;
            default: v = 19'sd0;
        endcase
        return v;
    endfunction

endpackage

@@ src/chmc_cmd_if.sv @@
// ---------------------------------------------------------------------------
// chmc_cmd_if
// Command channel: a command code and one raw X/Y/Z magnetometer sample.
// ---------------------------------------------------------------------------
interface chmc_cmd_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             command;
    logic signed [chmc_pkg::SAMPLE_W-1:0]   x_sample;
    logic signed [chmc_pkg::SAMPLE_W-1:0]   y_sample;
    logic signed [chmc_pkg::SAMPLE_W-1:0]   z_sample;

    modport source (output valid, command, x_sample, y_sample, z_sample, input ready);
    modport sink   (input valid, command, x_sample, y_sample, z_sample, output ready);
endinterface

@@ src/chmc_res_if.sv @@
// ---------------------------------------------------------------------------
// chmc_res_if
// Result channel: sample status and last valid heading.
// ---------------------------------------------------------------------------
interface chmc_res_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         status;
    logic [chmc_pkg::HEADING_W-1:0]     heading;

    modport source (output valid, status, heading, input ready);
    modport sink   (input valid, status, heading, output ready);
endinterface

@@ src/chmc_cordic.sv @@
// ---------------------------------------------------------------------------
// chmc_cordic
// Iterative vectoring CORDIC: one rotation step per cycle on a shared
// add/shift datapath, giving atan2(dy, dx) in degrees with 8 fraction bits.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module chmc_cordic #(
    parameter int CORDIC_STEPS = chmc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic signed [chmc_pkg::DXY_W-1:0]      dx,
    input  logic signed [chmc_pkg::DXY_W-1:0]      dy,
    output chmc_pkg::cordic_stat_t                 stat,
    output logic signed [chmc_pkg::ANGLE_W-1:0]    angle
);

    localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
    localparam int XY_W  = chmc_pkg::XY_W;
    localparam int EXT_W = XY_W - chmc_pkg::DXY_W - chmc_pkg::FRAC_SHIFT;

    logic signed [XY_W-1:0]              x_reg, y_reg;
    logic signed [chmc_pkg::ANGLE_W-1:0] z_reg;
    logic [STEP_W-1:0]                   step_reg;
    logic                                busy_reg, done_reg;

    logic signed [XY_W-1:0]              x0, y0, xs, ys;
    logic signed [chmc_pkg::ANGLE_W-1:0] t_step;

    assign x0 = {{EXT_W{dx[chmc_pkg::DXY_W-1]}}, dx, {chmc_pkg::FRAC_SHIFT{1'b0}}};
    assign y0 = {{EXT_W{dy[chmc_pkg::DXY_W-1]}}, dy, {chmc_pkg::FRAC_SHIFT{1'b0}}};

    // Shared shift unit: both axes shifted by the current step index.
    assign xs = x_reg >>> step_reg;
    assign ys = y_reg >>> step_reg;
    assign t_step = chmc_pkg::atan_q8(chmc_pkg::ATAN_IDX_W'(step_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                step_reg <= '0;
                if (dx == '0 && dy == '0)
                begin
                    // Zero vector has no direction; the angle is taken as zero.
                    z_reg    <= '0;
                    done_reg <= 1'b1;
                end
                else if (dx[chmc_pkg::DXY_W-1])
                begin
                    // Left half plane: rotate by a half turn first.
                    x_reg    <= -x0;
                    y_reg    <= -y0;
                    z_reg    <= dy[chmc_pkg::DXY_W-1] ? -chmc_pkg::HALF_TURN_Q8
                                                      : chmc_pkg::HALF_TURN_Q8;
                    busy_reg <= 1'b1;
                end
                else
                begin
                    x_reg    <= x0;
                    y_reg    <= y0;
                    z_reg    <= '0;
                    busy_reg <= 1'b1;
                end
            end
            else if (busy_reg)
            begin
                if (!y_reg[XY_W-1])
                begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + t_step;
                end
                else
                begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - t_step;
                end
                if (step_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
        end
    end

    assign stat  = chmc_pkg::cordic_stat_t'{busy: busy_reg, done: done_reg};
    assign angle = z_reg;

    `CHK_IMPLIES(a_start_when_idle, clk, rst_n, start, !busy_reg)

endmodule

@@ src/compass_heading_with_minmax_calibration_top.sv @@
// ---------------------------------------------------------------------------
// compass_heading_with_minmax_calibration_top
// Compass heading from raw magnetometer samples, with min/max hard-iron
// calibration and an iterative CORDIC for atan2.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload                                   Per transaction
//  --------  ---------  ----------------------------------------  ---------------
//  cmd       in         command, x_sample, y_sample, z_sample     one command
//  result    out        status, heading                           one result
//
// A clean sample passes through the offset, CORDIC launch, one step per cycle on the
// shared add/shift unit, heading capture and result load. A zero corrected vector
// skips the CORDIC steps. Other commands go straight to the result load. The command
// channel is ready only while the sequencer is idle, so no new command is accepted
// until the previous one has loaded its result. A result waits in the output
// register while the next command runs; a new result is loaded once that register
// is empty or being taken. Reset clears the calibration bounds and heading to zero
// and the status to "no sample yet".
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module compass_heading_with_minmax_calibration_top #(
    parameter int CORDIC_STEPS = chmc_pkg::CORDIC_STEPS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    chmc_cmd_if.sink    cmd,
    chmc_res_if.source  result
);

    localparam int SW = chmc_pkg::SAMPLE_W;
    localparam int DW = chmc_pkg::DXY_W;
    localparam int AW = chmc_pkg::ANGLE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OFFSET,
        S_START,
        S_CORDIC,
        S_EMIT
    } state_t;

    state_t                             state_reg;
    logic                               cal_reg;
    logic signed [SW-1:0]               x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic signed [SW-1:0]               xs_reg, ys_reg;
    logic signed [DW-1:0]               dx_reg, dy_reg;
    logic [1:0]                         last_status_reg;
    logic [chmc_pkg::HEADING_W-1:0]     last_heading_reg;
    logic                               res_valid_reg;
    logic [1:0]                         res_status_reg;
    logic [chmc_pkg::HEADING_W-1:0]     res_heading_reg;

    chmc_pkg::cordic_stat_t             cordic_stat;
    logic signed [AW-1:0]               cordic_angle;
    logic                               cordic_start;

    logic                               cmd_take;
    logic                               ovf;
    logic signed [SW:0]                 x_sum, y_sum, x_half, y_half;
    logic signed [DW-1:0]               dx_new, dy_new;
    logic signed [AW:0]                 t_q8;
    logic [chmc_pkg::HEADING_W-1:0]     heading_new;
    logic                               out_free;

    assign cmd.ready = (state_reg == S_IDLE);
    assign cmd_take  = cmd.valid && cmd.ready;

    // Any axis below the sensor's overflow code marks the sample as bad.
    assign ovf = (cmd.x_sample < chmc_pkg::OVF_LIMIT) ||
                 (cmd.y_sample < chmc_pkg::OVF_LIMIT) ||
                 (cmd.z_sample < chmc_pkg::OVF_LIMIT);

    // Hard-iron offset: floor((min + max) / 2), then subtract from the sample.
    assign x_sum  = {x_lo_reg[SW-1], x_lo_reg} + {x_hi_reg[SW-1], x_hi_reg};
    assign y_sum  = {y_lo_reg[SW-1], y_lo_reg} + {y_hi_reg[SW-1], y_hi_reg};
    assign x_half = x_sum >>> 1;
    assign y_half = y_sum >>> 1;
    assign dx_new = {{(DW-SW){xs_reg[SW-1]}}, xs_reg} - {{(DW-SW-1){x_half[SW]}}, x_half};
    assign dy_new = {{(DW-SW){ys_reg[SW-1]}}, ys_reg} - {{(DW-SW-1){y_half[SW]}}, y_half};

    // Angle plus a half turn, truncated to whole degrees and clamped.
    assign t_q8 = {cordic_angle[AW-1], cordic_angle}
                + {chmc_pkg::HALF_TURN_Q8[AW-1], chmc_pkg::HALF_TURN_Q8};
    always_comb
    begin
        if (t_q8[AW])
        begin
            heading_new = '0;
        end
        else if (t_q8[AW-1:8] > (AW-8)'(chmc_pkg::HEADING_MAX))
        begin
            heading_new = chmc_pkg::HEADING_MAX;
        end
        else
        begin
            heading_new = t_q8[chmc_pkg::HEADING_W+7:8];
        end
    end

    assign cordic_start = (state_reg == S_START);
    assign out_free     = !res_valid_reg || result.ready;

    chmc_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cordic_start),
        .dx    (dx_reg),
        .dy    (dy_reg),
        .stat  (cordic_stat),
        .angle (cordic_angle)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            cal_reg          <= 1'b0;
            x_lo_reg         <= '0;
            x_hi_reg         <= '0;
            y_lo_reg         <= '0;
            y_hi_reg         <= '0;
            xs_reg           <= '0;
            ys_reg           <= '0;
            dx_reg           <= '0;
            dy_reg           <= '0;
            last_status_reg  <= chmc_pkg::ST_NONE;
            last_heading_reg <= '0;
            res_valid_reg    <= 1'b0;
            res_status_reg   <= chmc_pkg::ST_NONE;
            res_heading_reg  <= '0;
        end
        else
        begin
            // In the emit state the load below decides the valid flag.
            if (res_valid_reg && result.ready && state_reg != S_EMIT)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_take)
                    begin
                        state_reg <= S_EMIT;
                        case (cmd.command)
                            chmc_pkg::CMD_START:
                            begin
                                // A second start while running keeps the bounds.
                                if (!cal_reg)
                                begin
                                    cal_reg  <= 1'b1;
                                    x_lo_reg <= chmc_pkg::CAL_LOW_INIT;
                                    x_hi_reg <= chmc_pkg::CAL_HIGH_INIT;
                                    y_lo_reg <= chmc_pkg::CAL_LOW_INIT;
                                    y_hi_reg <= chmc_pkg::CAL_HIGH_INIT;
                                end
                            end
                            chmc_pkg::CMD_STOP:
                            begin
                                cal_reg <= 1'b0;
                            end
                            chmc_pkg::CMD_SAMPLE:
                            begin
                                if (ovf)
                                begin
                                    last_status_reg <= chmc_pkg::ST_OVF;
                                end
                                else
                                begin
                                    last_status_reg <= chmc_pkg::ST_OK;
                                    xs_reg          <= cmd.x_sample;
                                    ys_reg          <= cmd.y_sample;
                                    state_reg       <= S_OFFSET;
                                    if (cal_reg)
                                    begin
                                        if (cmd.x_sample < x_lo_reg) x_lo_reg <= cmd.x_sample;
                                        if (cmd.x_sample > x_hi_reg) x_hi_reg <= cmd.x_sample;
                                        if (cmd.y_sample < y_lo_reg) y_lo_reg <= cmd.y_sample;
                                        if (cmd.y_sample > y_hi_reg) y_hi_reg <= cmd.y_sample;
                                    end
                                end
                            end
                            default:
                            begin
                                // Unused code: result repeats the stored values.
                            end
                        endcase
                    end
                end
                S_OFFSET:
                begin
                    dx_reg    <= dx_new;
                    dy_reg    <= dy_new;
                    state_reg <= S_START;
                end
                S_START:
                begin
                    state_reg <= S_CORDIC;
                end
                S_CORDIC:
                begin
                    if (cordic_stat.done)
                    begin
                        last_heading_reg <= heading_new;
                        state_reg        <= S_EMIT;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        res_valid_reg   <= 1'b1;
                        res_status_reg  <= last_status_reg;
                        res_heading_reg <= last_heading_reg;
                        state_reg       <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid   = res_valid_reg;
    assign result.status  = res_status_reg;
    assign result.heading = res_heading_reg;

    `CHK_IMPLIES(a_heading_range, clk, rst_n, 1'b1, last_heading_reg <= chmc_pkg::HEADING_MAX)
    `CHK_IMPLIES(a_done_in_cordic, clk, rst_n, cordic_stat.done, state_reg == S_CORDIC)
    `CHK_NEXT(a_busy_after_take, clk, rst_n, cmd_take, !cmd.ready)
    `CHK_IMPLIES(a_cordic_idle_outside, clk, rst_n, cordic_stat.busy, state_reg == S_CORDIC)

endmodule

@@ tb/sv/tb_compass_heading_with_minmax_calibration_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_compass_heading_with_minmax_calibration_top
// Self-checking testbench for the compass heading block. Commands go in on
// the command channel and every accepted transaction is run through a local
// model of the calibration state and the CORDIC heading. The expected result
// is queued and compared, field by field, with each result transaction.
// Directed cases come first, then a receiver hold-off that backs up the
// block, then about a thousand random transactions with random idling on
// both channels.
// ---------------------------------------------------------------------------
module tb_compass_heading_with_minmax_calibration_top;

    localparam int     CORDIC_STEPS    = chmc_pkg::CORDIC_STEPS_DEF;
    localparam int     SW              = chmc_pkg::SAMPLE_W;
    localparam int     HW              = chmc_pkg::HEADING_W;
    localparam int     CLK_PERIOD      = 8;
    localparam int     RESET_CYCLES    = 8;
    localparam int     RANDOM_ITEMS    = 1000;
    localparam int     HOLD_OFF_CYCLES = 300;
    localparam int     BURST_ITEMS     = 24;
    localparam int     DRAIN_CYCLES    = 2 * (CORDIC_STEPS + 5);
    localparam int     MAX_REPORTS     = 10;
    localparam longint TIMEOUT_NS      = 5_000_000;

    // The package defines no name for the fourth command code.
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // The angle for half a turn, degrees with 8 fraction bits.
    localparam longint HALF_TURN_DEG_Q8 = 46080;

    typedef struct packed {
        logic [1:0]    status;
        logic [HW-1:0] heading;
    } compass_result_t;

    logic clk;
    logic rst_n;

    chmc_cmd_if cmd_bus ();
    chmc_res_if res_bus ();

    compass_heading_with_minmax_calibration_top #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_bus),
        .result (res_bus)
    );

    // -----------------------------------------------------------------------
    // Local copy of the block's state, advanced once per accepted command.
    // -----------------------------------------------------------------------
    logic                  cal_active;
    logic signed [SW-1:0]  x_min;
    logic signed [SW-1:0]  x_max;
    logic signed [SW-1:0]  y_min;
    logic signed [SW-1:0]  y_max;
    logic [HW-1:0]         held_heading;
    logic [1:0]            held_status;

    // Results that the block still owes, oldest first.
    compass_result_t pending_results [$];

    // Knobs shared by the stimulus processes.
    bit tx_idle_en;
    bit rx_idle_en;
    int hold_off_requests;

    // Run statistics and failure count.
    int error_count;
    int results_checked;
    int n_samples;
    int n_overflow;
    int n_cal_cmds;
    int n_unused;

    // -----------------------------------------------------------------------
    // Clock and reset. Reset is asserted once, at the very start.
    // -----------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // A hard limit on the run, far beyond the slowest correct run.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout: %0d results still outstanding.", pending_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Prediction.
    // -----------------------------------------------------------------------

    // atan(2^-i) in degrees with 8 fraction bits, rounded to nearest.
    function automatic longint atan_step_q8(input int i);
        case (i)
            0:       return 11520;
            1:       return 6801;
            2:       return 3593;
            3:       return 1824;
            4:       return 916;
            5:       return 458;
            6:       return 229;
            7:       return 115;
            8:       return 57;
            9:       return 29;
            10:      return 14;
            11:      return 7;
            12:      return 4;
            13:      return 2;
            14:      return 1;
            default: return 0;
        endcase
    endfunction

    // Hard-iron offset of one axis: the midpoint of the bounds, rounded down.
    function automatic int axis_offset(input logic signed [SW-1:0] lo,
                                       input logic signed [SW-1:0] hi);
        int sum;
        sum = int'(lo) + int'(hi);
        return sum >>> 1;
    endfunction

    // Vectoring CORDIC on the offset-corrected vector, then the shift to
    // 0..360 degrees, truncation and the clamp to 0..359.
    function automatic logic [HW-1:0] cordic_heading(input int dx, input int dy);
        longint vx;
        longint vy;
        longint ang;
        longint sx;
        longint sy;
        longint turn;
        int     i;
        vx  = longint'(dx) * (longint'(1) << chmc_pkg::FRAC_SHIFT);
        vy  = longint'(dy) * (longint'(1) << chmc_pkg::FRAC_SHIFT);
        ang = 0;
        if (dx != 0 || dy != 0)
        begin
            // Fold the left half plane onto the right one.
            if (vx < 0)
            begin
                ang = (vy >= 0) ? HALF_TURN_DEG_Q8 : -HALF_TURN_DEG_Q8;
                vx  = -vx;
                vy  = -vy;
            end
            for (i = 0; i < CORDIC_STEPS && i < chmc_pkg::ATAN_ENTRIES; i++)
            begin
                sx = vx >>> i;
                sy = vy >>> i;
                if (vy >= 0)
                begin
                    vx  = vx + sy;
                    vy  = vy - sx;
                    ang = ang + atan_step_q8(i);
                end
                else
                begin
                    vx  = vx - sy;
                    vy  = vy + sx;
                    ang = ang - atan_step_q8(i);
                end
            end
        end
        turn = ang + HALF_TURN_DEG_Q8;
        if (turn < 0)
            return '0;
        turn = turn >>> 8;
        if (turn > longint'(chmc_pkg::HEADING_MAX))
            turn = longint'(chmc_pkg::HEADING_MAX);
        return turn[HW-1:0];
    endfunction

    // Applies one command to the local state and returns the result it causes.
    function automatic compass_result_t apply_command(input logic [1:0] code,
                                                      input logic signed [SW-1:0] xs,
                                                      input logic signed [SW-1:0] ys,
                                                      input logic signed [SW-1:0] zs);
        compass_result_t res;
        case (code)
            chmc_pkg::CMD_START:
            begin
                // A start while calibrating leaves the bounds alone.
                if (!cal_active)
                begin
                    cal_active = 1'b1;
                    x_min      = chmc_pkg::CAL_LOW_INIT;
                    x_max      = chmc_pkg::CAL_HIGH_INIT;
                    y_min      = chmc_pkg::CAL_LOW_INIT;
                    y_max      = chmc_pkg::CAL_HIGH_INIT;
                end
            end
            chmc_pkg::CMD_STOP:
                cal_active = 1'b0;
            chmc_pkg::CMD_SAMPLE:
            begin
                if (xs < chmc_pkg::OVF_LIMIT || ys < chmc_pkg::OVF_LIMIT ||
                    zs < chmc_pkg::OVF_LIMIT)
                begin
                    held_status = chmc_pkg::ST_OVF;
                end
                else
                begin
                    held_status = chmc_pkg::ST_OK;
                    if (cal_active)
                    begin
                        if (xs < x_min) x_min = xs;
                        if (xs > x_max) x_max = xs;
                        if (ys < y_min) y_min = ys;
                        if (ys > y_max) y_max = ys;
                    end
                    held_heading = cordic_heading(int'(xs) - axis_offset(x_min, x_max),
                                                  int'(ys) - axis_offset(y_min, y_max));
                end
            end
            default: ;
        endcase
        res.status  = held_status;
        res.heading = held_heading;
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Monitor and scoreboard. Both channels are sampled at the rising edge,
    // so the values seen are the ones the block saw at that edge. A command
    // transaction can never produce its result at the same edge, so the
    // expectation is always queued first.
    // -----------------------------------------------------------------------
    always @(posedge clk)
    begin
        compass_result_t exp_res;
        if (cmd_bus.valid === 1'b1 && cmd_bus.ready === 1'b1)
        begin
            case (cmd_bus.command)
                chmc_pkg::CMD_SAMPLE:
                begin
                    n_samples++;
                    if (cmd_bus.x_sample < chmc_pkg::OVF_LIMIT ||
                        cmd_bus.y_sample < chmc_pkg::OVF_LIMIT ||
                        cmd_bus.z_sample < chmc_pkg::OVF_LIMIT)
                        n_overflow++;
                end
                chmc_pkg::CMD_START, chmc_pkg::CMD_STOP: n_cal_cmds++;
                default:                                 n_unused++;
            endcase
            pending_results.push_back(apply_command(cmd_bus.command, cmd_bus.x_sample,
                                                    cmd_bus.y_sample, cmd_bus.z_sample));
        end
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: result transaction with none expected: %s %0d heading %0d",
                             $realtime, "status", res_bus.status, res_bus.heading);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (res_bus.status !== exp_res.status || res_bus.heading !== exp_res.heading)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display({"%0t: result %0d: expected status %0d heading %0d, ",
                                  "got status %0d heading %0d"},
                                 $realtime, results_checked, exp_res.status, exp_res.heading,
                                 res_bus.status, res_bus.heading);
                end
            end
        end
    end

    // -----------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then a long one.
    // -----------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 4);
        else
            return $urandom_range(12, 48);
    endfunction

    // -----------------------------------------------------------------------
    // Result receiver. Ready is decided once per cycle. A hold-off request
    // from a test task makes it drop ready for a long stretch, counted here.
    // -----------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int rx_gap;
        int served;
        hold_left = 0;
        rx_gap    = 0;
        served    = 0;
        res_bus.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_requests != served)
            begin
                served    = hold_off_requests;
                hold_left = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end
            else if (rx_gap > 0)
            begin
                rx_gap--;
                res_bus.ready <= 1'b0;
            end
            else
            begin
                res_bus.ready <= 1'b1;
                rx_gap = rx_idle_en ? idle_gap() : 0;
            end
        end
    end

    // -----------------------------------------------------------------------
    // Command sender. It is entered at a rising edge, offers the transaction
    // until it is taken, then idles for a random gap. With no gap, valid
    // simply stays high for the next transaction.
    // -----------------------------------------------------------------------
    task automatic send_command(input logic [1:0] code,
                                input logic signed [SW-1:0] xs,
                                input logic signed [SW-1:0] ys,
                                input logic signed [SW-1:0] zs);
        int gap;
        cmd_bus.valid    <= 1'b1;
        cmd_bus.command  <= code;
        cmd_bus.x_sample <= xs;
        cmd_bus.y_sample <= ys;
        cmd_bus.z_sample <= zs;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        gap = tx_idle_en ? idle_gap() : 0;
        if (gap > 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Calibration and unused commands carry junk payloads that must be ignored.
    task automatic send_control(input logic [1:0] code);
        send_command(code, SW'($urandom), SW'($urandom), SW'($urandom));
    endtask

    // Axis value: mostly a plausible clean reading, sometimes anything at all,
    // sometimes right at the overflow edge or the top of the range.
    function automatic logic signed [SW-1:0] rand_axis();
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 65)
            v = int'($urandom_range(0, 6000)) - 2048;
        else if (r < 80)
            v = int'($urandom_range(0, 65535));
        else if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0:       v = -2048;
                1:       v = -2049;
                2:       v = 32767;
                default: v = -32768;
            endcase
        end
        else
            v = int'($urandom_range(0, 100)) - 50;
        return v[SW-1:0];
    endfunction

    task automatic send_random_sample();
        send_command(chmc_pkg::CMD_SAMPLE, rand_axis(), rand_axis(), rand_axis());
    endtask

    // -----------------------------------------------------------------------
    // Test tasks.
    // -----------------------------------------------------------------------

    // Before any sample the block reports "no sample yet" with heading zero,
    // for a stop and for the unused code alike. With zero bounds, a zero
    // sample is a zero vector, whose heading is 180.
    task automatic test_after_reset();
        send_control(chmc_pkg::CMD_STOP);
        send_control(CMD_UNUSED);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd0, 16'sd0, 16'sd0);
    endtask

    // Field extremes, the overflow edge on each axis, and the angles next to
    // the half-turn fold where the heading clamps to 359 or floors to 0.
    task automatic test_sample_extremes();
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd32767, 16'sd0, 16'sd32767);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd2048, -16'sd2048, -16'sd2048);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd32767, 16'sd32767, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd2049, 16'sd100, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd100, -16'sd32768, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd100, 16'sd100, -16'sd2049);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd1000, 16'sd0, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd1000, -16'sd1, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd0, -16'sd2048, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd0, 16'sd32767, -16'sd32768);
    endtask

    // A calibration session: a second start that must not reset the bounds,
    // bounds widening, an overflow that must not touch them, then a stop and
    // a sample at the exact center, followed by a fresh start from idle.
    task automatic test_calibration();
        send_control(chmc_pkg::CMD_START);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd100, 16'sd200, 16'sd0);
        send_control(chmc_pkg::CMD_START);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd500, -16'sd300, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd2001, 16'sd1500, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd3000, 16'sd3000, -16'sd3000);
        send_control(CMD_UNUSED);
        send_control(chmc_pkg::CMD_STOP);
        send_command(chmc_pkg::CMD_SAMPLE, 16'sd750, 16'sd600, 16'sd0);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd2000, 16'sd600, 16'sd0);
        send_control(chmc_pkg::CMD_START);
        send_command(chmc_pkg::CMD_SAMPLE, -16'sd7, 16'sd9, 16'sd0);
        send_control(chmc_pkg::CMD_STOP);
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering back-to-back transactions, so the block fills and stalls.
    task automatic test_backpressure();
        bit saved_tx;
        int k;
        saved_tx   = tx_idle_en;
        tx_idle_en = 1'b0;
        hold_off_requests <= hold_off_requests + 1;
        for (k = 0; k < BURST_ITEMS; k++)
            send_random_sample();
        tx_idle_en = saved_tx;
    endtask

    // Mostly calibration sessions and plain samples with random content;
    // stray starts, stops and unused codes mixed in as noise.
    task automatic test_random_traffic();
        int sent;
        int chunk_mark;
        int r;
        int k;
        int sweep_len;
        sent       = 0;
        chunk_mark = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // Now and then switch idling off on one side or both.
            if (sent >= chunk_mark)
            begin
                chunk_mark = sent + 100;
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                sweep_len = $urandom_range(5, 30);
                send_control(chmc_pkg::CMD_START);
                for (k = 0; k < sweep_len; k++)
                    send_random_sample();
                if ($urandom_range(0, 3) != 0)
                    send_control(chmc_pkg::CMD_STOP);
                sent += sweep_len + 2;
            end
            else
            begin
                if (r < 12)
                    send_control(CMD_UNUSED);
                else if (r < 15)
                    send_control(chmc_pkg::CMD_STOP);
                else if (r < 18)
                    send_control(chmc_pkg::CMD_START);
                else
                    send_random_sample();
                sent++;
            end
        end
    endtask

    // -----------------------------------------------------------------------
    // Main sequence.
    // -----------------------------------------------------------------------
    initial
    begin
        cal_active        = 1'b0;
        x_min             = '0;
        x_max             = '0;
        y_min             = '0;
        y_max             = '0;
        held_heading      = '0;
        held_status       = chmc_pkg::ST_NONE;
        tx_idle_en        = 1'b1;
        rx_idle_en        = 1'b1;
        hold_off_requests = 0;
        error_count       = 0;
        results_checked   = 0;
        n_samples         = 0;
        n_overflow        = 0;
        n_cal_cmds        = 0;
        n_unused          = 0;

        rst_n            <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.command  <= chmc_pkg::CMD_SAMPLE;
        cmd_bus.x_sample <= '0;
        cmd_bus.y_sample <= '0;
        cmd_bus.z_sample <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_after_reset();
        test_sample_extremes();
        test_calibration();
        test_backpressure();
        test_random_traffic();

        cmd_bus.valid <= 1'b0;

        // Let every owed result come back, then give the block time to show
        // any result that should not be there.
        rx_idle_en = 1'b1;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            error_count += pending_results.size();
            $display("%0d expected results never arrived.", pending_results.size());
        end

        $display("Sent %0d commands: %0d samples (%0d overflow), %0d start/stop, %0d unused.",
                 n_samples + n_cal_cmds + n_unused, n_samples, n_overflow, n_cal_cmds,
                 n_unused);
        $display("Checked %0d results, including a %0d-cycle receiver hold-off.",
                 results_checked, HOLD_OFF_CYCLES);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
